// File: sv/pma_pkg.sv
// Shared types and constants for the palette match allocator.
// Used by pma_ctrl and the palette_match_allocator top level; depends on nothing.
package pma_pkg;

  // Packed colour: red in the top byte, then green, then blue.
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned RGB_W  = 3 * CHAN_W;
  localparam int unsigned SLOT_W = 4;

  typedef logic [RGB_W-1:0]  rgb_t;
  typedef logic [SLOT_W-1:0] slot_t;

  localparam rgb_t WHITE_RGB = {RGB_W{1'b1}};
  localparam rgb_t BLACK_RGB = '0;

  // Opcodes of an input transaction; the fourth code does nothing.
  typedef enum logic [1:0] {
    OP_SET_FG = 2'd0,
    OP_SET_BG = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_CLR_BG,
    ST_CLR_FG,
    ST_DONE
  } state_t;

  // Finished result handed from the sequencer to the output register.
  typedef struct packed {
    logic  valid;
    slot_t assigned_index;
    logic  new_entry;
    logic  table_full;
    slot_t fg_index;
    slot_t bg_index;
    slot_t top_entry;
  } result_t;

endpackage

// File: sv/pma_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; holds the palette entries for the allocator.
module pma_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/pma_ctrl.sv
// Sequencer of the palette match allocator: colour and slot state, the scan
// over the palette RAM with one shared comparator, and palette rebuild.
// Depends on pma_pkg; drives the pma_ram ports from the top level.
module pma_ctrl import pma_pkg::*; #(
  parameter int unsigned PALETTE_ENTRIES = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic [1:0]                         in_opcode,
  input  rgb_t                               in_rgb,
  output logic                               busy,
  input  logic                               out_free,
  output result_t                            res,
  output logic                               ram_we,
  output logic [$clog2(PALETTE_ENTRIES)-1:0] ram_waddr,
  output rgb_t                               ram_wdata,
  output logic [$clog2(PALETTE_ENTRIES)-1:0] ram_raddr,
  input  rgb_t                               ram_rdata
);

  localparam int unsigned IDX_W = $clog2(PALETTE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);
  localparam logic [IDX_W-1:0] IDX_ZERO = '0;
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

  state_t           state_r,   state_nxt;
  opcode_t          op_r,      op_nxt;
  rgb_t             rgb_r,     rgb_nxt;
  rgb_t             fg_rgb_r,  fg_rgb_nxt;
  rgb_t             bg_rgb_r,  bg_rgb_nxt;
  logic [IDX_W-1:0] fg_slot_r, fg_slot_nxt;
  logic [IDX_W-1:0] bg_slot_r, bg_slot_nxt;
  logic [IDX_W-1:0] top_r,     top_nxt;
  logic [IDX_W-1:0] cnt_r,     cnt_nxt;
  logic [IDX_W-1:0] idx_r,     idx_nxt;
  logic             added_r,   added_nxt;
  logic             full_r,    full_nxt;
  logic             e0_wr_r,   e0_wr_nxt;

  logic [IDX_W-1:0] cnt_inc;
  logic [IDX_W-1:0] hit_idx;
  rgb_t             entry;
  logic             hit;
  logic             finish;
  logic             chans_differ;

  // Entry 0 reads as black until it has been written after reset.
  assign entry   = (cnt_r == IDX_ZERO && !e0_wr_r) ? BLACK_RGB : ram_rdata;
  // The one shared comparator of the scan.
  assign hit     = (entry == rgb_r);
  assign cnt_inc = IDX_W'(cnt_r + 1'b1);

  assign chans_differ = (bg_rgb_r[23:16] != fg_rgb_r[23:16]) &&
                        (bg_rgb_r[15:8]  != fg_rgb_r[15:8])  &&
                        (bg_rgb_r[7:0]   != fg_rgb_r[7:0]);

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fg_rgb_r  <= WHITE_RGB;
      bg_rgb_r  <= BLACK_RGB;
      fg_slot_r <= IDX_ONE;
      bg_slot_r <= IDX_ZERO;
      top_r     <= IDX_ZERO;
      e0_wr_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fg_rgb_r  <= fg_rgb_nxt;
      bg_rgb_r  <= bg_rgb_nxt;
      fg_slot_r <= fg_slot_nxt;
      bg_slot_r <= bg_slot_nxt;
      top_r     <= top_nxt;
      e0_wr_r   <= e0_wr_nxt;
    end
  end

  // Per-transaction working registers.
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    rgb_r   <= rgb_nxt;
    cnt_r   <= cnt_nxt;
    idx_r   <= idx_nxt;
    added_r <= added_nxt;
    full_r  <= full_nxt;
  end

  // Next state and RAM control.
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    rgb_nxt     = rgb_r;
    fg_rgb_nxt  = fg_rgb_r;
    bg_rgb_nxt  = bg_rgb_r;
    fg_slot_nxt = fg_slot_r;
    bg_slot_nxt = bg_slot_r;
    top_nxt     = top_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    added_nxt   = added_r;
    full_nxt    = full_r;
    e0_wr_nxt   = e0_wr_r;
    ram_we      = 1'b0;
    ram_waddr   = IDX_ZERO;
    ram_wdata   = rgb_r;
    ram_raddr   = IDX_ZERO;
    finish      = 1'b0;
    hit_idx     = cnt_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = opcode_t'(in_opcode);
          rgb_nxt   = in_rgb;
          cnt_nxt   = IDX_ZERO;
          idx_nxt   = IDX_ZERO;
          added_nxt = 1'b0;
          full_nxt  = 1'b0;
          case (opcode_t'(in_opcode))
            OP_SET_FG: begin
              fg_rgb_nxt = in_rgb;
              state_nxt  = ST_START;
            end
            OP_SET_BG: begin
              bg_rgb_nxt = in_rgb;
              state_nxt  = ST_START;
            end
            OP_CLEAR: begin
              state_nxt = ST_CLR_BG;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_START: begin
        // Entry 0 is read here; its data is compared in the first scan cycle.
        ram_raddr = IDX_ZERO;
        state_nxt = ST_SCAN;
      end

      ST_SCAN: begin
        // Compare entry cnt while fetching the next one.
        ram_raddr = cnt_inc;
        if (hit) begin
          hit_idx = cnt_r;
          finish  = 1'b1;
        end else if (cnt_r == top_r) begin
          if (cnt_r == LAST_IDX) begin
            hit_idx  = IDX_ZERO;
            full_nxt = 1'b1;
          end else begin
            hit_idx   = cnt_inc;
            ram_we    = 1'b1;
            ram_waddr = cnt_inc;
            ram_wdata = rgb_r;
            top_nxt   = cnt_inc;
            added_nxt = 1'b1;
          end
          finish = 1'b1;
        end else begin
          cnt_nxt = cnt_inc;
        end
        if (finish) begin
          idx_nxt = hit_idx;
          if (op_r == OP_SET_FG) begin
            fg_slot_nxt = hit_idx;
          end else begin
            bg_slot_nxt = hit_idx;
          end
          state_nxt = ST_DONE;
        end
      end

      ST_CLR_BG: begin
        // Entry 0 takes the background; the foreground joins only if every channel differs.
        ram_we      = 1'b1;
        ram_waddr   = IDX_ZERO;
        ram_wdata   = bg_rgb_r;
        e0_wr_nxt   = 1'b1;
        bg_slot_nxt = IDX_ZERO;
        if (chans_differ) begin
          top_nxt     = IDX_ONE;
          fg_slot_nxt = IDX_ONE;
          state_nxt   = ST_CLR_FG;
        end else begin
          top_nxt   = IDX_ZERO;
          state_nxt = ST_DONE;
          if (bg_rgb_r == BLACK_RGB) begin
            // Black background and a foreground sharing a channel: fall back to black and white.
            // Entry 1 lies above the top entry and is never read, so it is
            // not written.
            fg_rgb_nxt  = WHITE_RGB;
            fg_slot_nxt = IDX_ONE;
          end else begin
            fg_slot_nxt = IDX_ZERO;
          end
        end
      end

      ST_CLR_FG: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_ONE;
        ram_wdata = fg_rgb_r;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  // Result fields, taken from the final state of the transaction.
  assign res.valid          = (state_r == ST_DONE);
  assign res.assigned_index = slot_t'(idx_r);
  assign res.new_entry      = added_r;
  assign res.table_full     = full_r;
  assign res.fg_index       = slot_t'(fg_slot_r);
  assign res.bg_index       = slot_t'(bg_slot_r);
  assign res.top_entry      = slot_t'(top_r);

  // The scan never runs past the top entry.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> cnt_r <= top_r)
    else $error("scan index passed the top entry");

  // A full table is only reported when the last entry is in use.
  a_full_top: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && full_r |-> top_r == LAST_IDX && idx_r == IDX_ZERO)
    else $error("table full reported with free entries");

  // An appended entry becomes the new top entry and the slot of the item.
  a_append_top: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && added_r |-> idx_r == top_r &&
      (fg_slot_r == top_r || bg_slot_r == top_r))
    else $error("appended entry is not the top entry");

  // A clear always leaves the background in slot 0.
  a_clear_bg: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLR_BG |=> bg_slot_r == IDX_ZERO && top_r <= IDX_ONE)
    else $error("clear left a bad background slot or top entry");

endmodule

// File: sv/palette_match_allocator.sv
// Palette match allocator: a PALETTE_ENTRIES-entry RGB palette. A set-foreground
// or set-background transaction scans the palette from entry 0 up to the top
// entry with a single comparator fed by the palette RAM's one read port, one
// entry per cycle, and takes the first exact match or appends the colour just
// above the top entry (flagging table_full and index 0 when no entry is free).
// The input stalls while a transaction is in work; a finished result waits in
// the output register, so the next transaction is accepted while it is still
// pending. No clearing pass is needed after reset.
module palette_match_allocator import pma_pkg::*; #(
  parameter int unsigned PALETTE_ENTRIES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_opcode,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_assigned_index,
  output logic       out_new_entry,
  output logic       out_table_full,
  output logic [3:0] out_fg_index,
  output logic [3:0] out_bg_index,
  output logic [3:0] out_top_entry
);

  localparam int unsigned IDX_W = $clog2(PALETTE_ENTRIES);

  logic             busy;
  logic             out_free;
  result_t          res;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  rgb_t             ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  rgb_t             ram_rdata;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_r,       out_nxt;

  // Sequencer with the shared comparator.
  pma_ctrl #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_opcode(in_opcode),
    .in_rgb   ({in_red, in_green, in_blue}),
    .busy     (busy),
    .out_free (out_free),
    .res      (res),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata)
  );

  // Palette entries.
  pma_ram #(
    .WIDTH(RGB_W),
    .DEPTH(PALETTE_ENTRIES)
  ) u_palette (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_stall = busy;

  // Output register: loads a finished result once the previous one is taken.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_free) begin
      out_valid_nxt = res.valid;
      if (res.valid) begin
        out_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_assigned_index = out_r.assigned_index;
  assign out_new_entry      = out_r.new_entry;
  assign out_table_full     = out_r.table_full;
  assign out_fg_index       = out_r.fg_index;
  assign out_bg_index       = out_r.bg_index;
  assign out_top_entry      = out_r.top_entry;

  // A finished result is never dropped while the output register is stalled.
  a_hold_done: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && out_valid_r && out_stall |=> res.valid)
    else $error("finished result left while output was stalled");

  // A new result is loaded only when the sequencer has one.
  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_free && !res.valid |=> !out_valid_r)
    else $error("output valid without a finished result");

  // No input is taken while a finished result waits in the sequencer.
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> in_stall)
    else $error("input ready while a result is pending in the sequencer");

endmodule
